@@ rtl/core/lme_pkg.sv @@
// lme_pkg: shared types and constants for the lsb message extractor
// depends on nothing; used by lsb_message_extractor
package lme_pkg;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_FOUND = 2'd1;
  localparam logic [1:0] KIND_FAIL  = 2'd2;

  localparam logic [7:0] DELIM_RESET = 8'd35;

  // result queue: two slots for the current request plus two in flight
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } result_t;

endpackage

@@ rtl/core/lsb_message_extractor.sv @@
// lsb_message_extractor: recovers a text message from the lsb of image bytes
// and stops at a run of three delimiter characters; uses lme_pkg
//
// channel   signals                                    direction
// cfg       delimiter_we, delimiter_char               in
// in        in_valid/in_ready, sample_byte, image_end  in
// out       out_valid/out_ready, kind, char_out,
//           last_result                                out
//
// one request is taken per cycle while in_ready is high; its zero, one or two
// results enter a four-entry result queue at the accepting edge and can leave
// from the next cycle, one per cycle while out_ready is high. in_ready is high
// while the queue holds at most two results. rst (synchronous) empties the
// queue, clears the bit state and sets the delimiter to '#'. a stalled output
// holds off input once three results wait.
module lsb_message_extractor (
  input  logic       clk,
  input  logic       rst,
  input  logic       delimiter_we,
  input  logic [7:0] delimiter_char,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] sample_byte,
  input  logic       image_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] char_out,
  output logic       last_result
);

  logic [7:0] delim;
  logic [7:0] bit_shift;
  logic [2:0] bits_gathered;
  logic [7:0] held_chars [2];
  logic [1:0] held_count;
  logic       found_flag;

  logic [7:0] bit_shift_next;
  logic [2:0] bits_gathered_next;
  logic [7:0] held0_next;
  logic [7:0] held1_next;
  logic [1:0] held_count_next;
  logic       found_flag_next;

  lme_pkg::result_t res0;
  lme_pkg::result_t res1;
  logic [1:0]       res_n;

  lme_pkg::result_t             queue [lme_pkg::QDEPTH];
  logic [lme_pkg::QPTR_W-1:0]   wr_ptr;
  logic [lme_pkg::QPTR_W-1:0]   rd_ptr;
  logic [lme_pkg::QCNT_W-1:0]   count;

  logic in_fire;
  logic out_fire;
  logic [lme_pkg::QCNT_W-1:0] push_n;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = count <= lme_pkg::QCNT_W'(lme_pkg::QDEPTH - 2);
  assign out_valid = count != '0;

  assign kind        = queue[rd_ptr].kind;
  assign char_out    = queue[rd_ptr].ch;
  assign last_result = queue[rd_ptr].last;

  // per-request update of the character state and its results
  always_comb begin
    logic [7:0]       c;
    logic             char_done;
    lme_pkg::result_t first;
    logic             has_first;
    logic             fail;

    c                  = {bit_shift[6:0], sample_byte[0]};
    char_done          = 1'b0;
    bit_shift_next     = bit_shift;
    bits_gathered_next = bits_gathered;
    held0_next         = held_chars[0];
    held1_next         = held_chars[1];
    held_count_next    = held_count;
    found_flag_next    = found_flag;
    first              = '{kind: lme_pkg::KIND_CHAR, ch: 8'd0, last: 1'b0};
    has_first          = 1'b0;
    fail               = 1'b0;

    if (!found_flag) begin
      if (bits_gathered == 3'd7) begin
        char_done          = 1'b1;
        bit_shift_next     = 8'd0;
        bits_gathered_next = 3'd0;
      end else begin
        bit_shift_next     = c;
        bits_gathered_next = bits_gathered + 3'd1;
      end
      if (char_done) begin
        if (held_count == 2'd2 && held_chars[0] == delim &&
            held_chars[1] == delim && c == delim) begin
          first           = '{kind: lme_pkg::KIND_FOUND, ch: 8'd0, last: 1'b0};
          has_first       = 1'b1;
          found_flag_next = 1'b1;
          held_count_next = 2'd0;
        end else if (held_count == 2'd2) begin
          first      = '{kind: lme_pkg::KIND_CHAR, ch: held_chars[0], last: 1'b0};
          has_first  = 1'b1;
          held0_next = held_chars[1];
          held1_next = c;
        end else begin
          if (held_count[0]) held1_next = c;
          else               held0_next = c;
          held_count_next = held_count + 2'd1;
        end
      end
      fail = image_end && !found_flag_next;
    end

    // results in order, last flag on the final one
    res1 = '{kind: lme_pkg::KIND_FAIL, ch: 8'd0, last: 1'b1};
    if (has_first) begin
      res0      = first;
      res0.last = !fail;
      res_n     = fail ? 2'd2 : 2'd1;
    end else begin
      res0  = '{kind: lme_pkg::KIND_FAIL, ch: 8'd0, last: 1'b1};
      res_n = fail ? 2'd1 : 2'd0;
    end

    // end of image clears everything but the delimiter
    if (image_end) begin
      bit_shift_next     = 8'd0;
      bits_gathered_next = 3'd0;
      held_count_next    = 2'd0;
      found_flag_next    = 1'b0;
    end
  end

  assign push_n = in_fire ? lme_pkg::QCNT_W'(res_n) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim <= lme_pkg::DELIM_RESET;
    end else if (delimiter_we) begin
      delim <= delimiter_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_shift     <= 8'd0;
      bits_gathered <= 3'd0;
      held_count    <= 2'd0;
      found_flag    <= 1'b0;
    end else if (in_fire) begin
      bit_shift     <= bit_shift_next;
      bits_gathered <= bits_gathered_next;
      held_count    <= held_count_next;
      found_flag    <= found_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_chars[0] <= held0_next;
      held_chars[1] <= held1_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (in_fire && res_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (in_fire && res_n == 2'd2) begin
      queue[wr_ptr + lme_pkg::QPTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[lme_pkg::QPTR_W-1:0];
      if (out_fire) rd_ptr <= rd_ptr + lme_pkg::QPTR_W'(1);
      count <= count + push_n - lme_pkg::QCNT_W'(out_fire);
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= lme_pkg::QCNT_W'(lme_pkg::QDEPTH))
    else $error("result queue overflow");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && image_end |=> bits_gathered == 3'd0 && held_count == 2'd0 && !found_flag)
    else $error("state not cleared after image end");

  a_found_no_held: assert property (@(posedge clk) disable iff (rst)
    found_flag |-> held_count == 2'd0 && bits_gathered == 3'd0)
    else $error("held characters remain after delimiter match");

  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == lme_pkg::KIND_FAIL |-> last_result)
    else $error("failure status not marked as final result");

endmodule

@@ tb/lsb_message_extractor_tb.sv @@
// lsb_message_extractor_tb: self-checking bench for the lsb message extractor
// predicts every result from its own copy of the bit and held-character state
// depends on lme_pkg and rtl/core/lsb_message_extractor.sv
module lsb_message_extractor_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 170;

  typedef struct {
    logic [7:0] sample;
    logic       last;
    bit         hold;
  } sample_req_t;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_BURSTY} ready_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       delimiter_we = 1'b0;
  logic [7:0] delimiter_char = lme_pkg::DELIM_RESET;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] sample_byte = 8'd0;
  logic       image_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic       last_result;

  lsb_message_extractor uut (
    .clk            (clk),
    .rst            (rst),
    .delimiter_we   (delimiter_we),
    .delimiter_char (delimiter_char),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_byte    (sample_byte),
    .image_end      (image_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .char_out       (char_out),
    .last_result    (last_result)
  );

  always #5 clk = ~clk;

  // predicted block state
  logic [7:0] pr_delim = lme_pkg::DELIM_RESET;
  logic [7:0] pr_shift = 8'd0;
  logic [2:0] pr_nbits = 3'd0;
  logic [7:0] pr_held [2];
  logic [1:0] pr_held_n = 2'd0;
  logic       pr_found = 1'b0;

  lme_pkg::result_t exp_results[$];
  sample_req_t      pending[$];
  sample_req_t      image_q[$];
  logic [7:0]       gen_delim = lme_pkg::DELIM_RESET;

  int errors = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_chars = 0;
  int n_found = 0;
  int n_fail = 0;

  task automatic predict_sample(input logic [7:0] s, input logic e);
    logic [7:0]       c;
    lme_pkg::result_t res [2];
    int               n;
    int               i;
    n = 0;
    if (!pr_found) begin
      c = {pr_shift[6:0], s[0]};
      pr_shift = c;
      if (pr_nbits == 3'd7) begin
        pr_shift = 8'd0;
        pr_nbits = 3'd0;
        if (pr_held_n == 2'd2 && pr_held[0] == pr_delim && pr_held[1] == pr_delim &&
            c == pr_delim) begin
          res[n] = '{kind: lme_pkg::KIND_FOUND, ch: 8'd0, last: 1'b0};
          n++;
          pr_found = 1'b1;
          pr_held_n = 2'd0;
        end else if (pr_held_n == 2'd2) begin
          res[n] = '{kind: lme_pkg::KIND_CHAR, ch: pr_held[0], last: 1'b0};
          n++;
          pr_held[0] = pr_held[1];
          pr_held[1] = c;
        end else begin
          pr_held[pr_held_n[0]] = c;
          pr_held_n = pr_held_n + 2'd1;
        end
      end else begin
        pr_nbits = pr_nbits + 3'd1;
      end
      if (e && !pr_found) begin
        res[n] = '{kind: lme_pkg::KIND_FAIL, ch: 8'd0, last: 1'b0};
        n++;
      end
    end
    if (e) begin
      pr_shift = 8'd0;
      pr_nbits = 3'd0;
      pr_held_n = 2'd0;
      pr_found = 1'b0;
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (i = 0; i < n; i++) exp_results.insert(exp_results.size(), res[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    $display("result %0d: %s is %h, predicted %h", n_checked, what, got, want);
  endtask

  // driver: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    sample_req_t it;
    bit          accept;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      accept = in_valid && in_ready;
      if (accept) begin
        predict_sample(sample_byte, image_end);
        n_accepted++;
      end
      if (!in_valid || accept) begin
        if (gap_left > 0 || pending.size() == 0 ||
            (pending[0].hold && exp_results.size() != 0)) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          it = pending.pop_front();
          in_valid <= 1'b1;
          sample_byte <= it.sample;
          image_end <= it.last;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // monitor: checks results and stalls on its own pattern
  ready_mode_t rdy_mode = RDY_ALWAYS;
  int rdy_cnt = 0;
  int rdy_period = 4;
  int rdy_duty = 2;
  int rdy_hold = 0;
  always @(posedge clk) begin
    lme_pkg::result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (exp_results.size() == 0) begin
          report_mismatch("kind with no prediction pending", {6'd0, kind}, 8'd0);
        end else begin
          want = exp_results.pop_front();
          if (kind !== want.kind) report_mismatch("kind", {6'd0, kind}, {6'd0, want.kind});
          if (char_out !== want.ch) report_mismatch("char_out", char_out, want.ch);
          if (last_result !== want.last)
            report_mismatch("last_result", {7'd0, last_result}, {7'd0, want.last});
          case (want.kind)
            lme_pkg::KIND_CHAR:  n_chars++;
            lme_pkg::KIND_FOUND: n_found++;
            default:             n_fail++;
          endcase
        end
      end
      rdy_cnt++;
      if (rdy_cnt % 256 == 0) begin
        rdy_mode = ready_mode_t'($urandom_range(0, 3));
        rdy_period = $urandom_range(2, 9);
        rdy_duty = $urandom_range(1, rdy_period - 1);
      end
      case (rdy_mode)
        RDY_ALWAYS:   out_ready <= 1'b1;
        RDY_COIN:     out_ready <= 1'($urandom_range(0, 1));
        RDY_PERIODIC: out_ready <= ((rdy_cnt % rdy_period) < rdy_duty);
        default: begin
          if (rdy_hold > 0) begin
            rdy_hold--;
            out_ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            rdy_hold = $urandom_range(5, 40);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // watchdog on cycles with no request or result moving
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("lsb_message_extractor: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_sample(input logic [7:0] s);
    sample_req_t it;
    it.sample = s;
    it.last = 1'b0;
    it.hold = 1'b0;
    image_q.insert(image_q.size(), it);
  endtask

  // one character as eight samples, msb first, random upper bits
  task automatic add_char(input logic [7:0] c);
    int i;
    for (i = 7; i >= 0; i--) add_sample((8'($urandom_range(0, 255)) & 8'hFE) | {7'd0, c[i]});
  endtask

  task automatic add_partial();
    int i;
    int nb;
    nb = $urandom_range(0, 7);
    for (i = 0; i < nb; i++) add_sample(8'($urandom_range(0, 255)));
  endtask

  // closes the image under construction and moves it to the driver queue
  task automatic commit_image(input bit hold_first);
    sample_req_t it;
    it = image_q.pop_back();
    it.last = 1'b1;
    image_q.insert(image_q.size(), it);
    if (hold_first) begin
      it = image_q.pop_front();
      it.hold = 1'b1;
      image_q.push_front(it);
    end
    while (image_q.size() > 0) pending.insert(pending.size(), image_q.pop_front());
  endtask

  task automatic queue_image(output int useful);
    int         style;
    int         nmsg;
    int         i;
    int         ntrail;
    logic [7:0] c;
    style = $urandom_range(0, 9);
    nmsg = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 4);
    for (i = 0; i < nmsg; i++) begin
      c = ($urandom_range(0, 4) == 0) ? gen_delim : 8'($urandom_range(0, 255));
      add_char(c);
    end
    if (style <= 4) begin
      // well-formed message, possibly with ignored trailing bytes
      repeat (3) add_char(gen_delim);
      useful = image_q.size();
      ntrail = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      for (i = 0; i < ntrail; i++) add_sample(8'($urandom_range(0, 255)));
    end else begin
      case (style)
        5: begin
          // two delimiters then a near miss
          repeat (2) add_char(gen_delim);
          add_char(gen_delim ^ (8'd1 << $urandom_range(0, 7)));
          add_partial();
        end
        6: begin
          // message with no added delimiter run, ending on a character boundary
          repeat (3) add_char(8'($urandom_range(0, 255)));
        end
        7: begin
          repeat ($urandom_range(1, 30)) add_sample(8'($urandom_range(0, 255)));
        end
        8: begin
          repeat ($urandom_range(1, 3)) add_sample(8'($urandom_range(0, 255)));
        end
        default: begin
          // delimiter run shifted by one bit
          add_sample(8'($urandom_range(0, 255)));
          repeat (3) add_char(gen_delim);
          add_partial();
        end
      endcase
      if (image_q.size() == 0) add_sample(8'($urandom_range(0, 255)));
      useful = image_q.size();
    end
    commit_image($urandom_range(0, 7) == 0);
  endtask

  // waits for an idle block: no request pending and every result back
  task automatic wait_idle(input int settle);
    while (pending.size() != 0 || in_valid || exp_results.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_delimiter(input logic [7:0] v);
    @(posedge clk);
    delimiter_we <= 1'b1;
    delimiter_char <= v;
    pr_delim = v;
    gen_delim = v;
    @(posedge clk);
    delimiter_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int ph;
    int budget;
    int u;
    logic [7:0] phase_delim [PHASES];
    phase_delim[0] = lme_pkg::DELIM_RESET;
    phase_delim[1] = 8'h00;
    phase_delim[2] = 8'hFF;
    phase_delim[3] = 8'($urandom_range(1, 254));
    phase_delim[4] = lme_pkg::DELIM_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_idle(8);
        write_delimiter(phase_delim[ph]);
      end
      if (ph == 0) begin
        // partial character dropped at image end
        add_sample(8'hFF);
        add_sample(8'h00);
        commit_image(1'b0);
        // image of a single byte
        add_sample(8'hFE);
        commit_image(1'b0);
        // match on the last byte of the image
        repeat (3) add_char(gen_delim);
        commit_image(1'b1);
      end
      budget = 0;
      while (budget < ITEMS_PER_PHASE) begin
        queue_image(u);
        budget += u;
      end
    end
    wait_idle(12);
    $display("sent %0d samples over %0d delimiter settings", n_accepted, PHASES);
    $display("checked %0d results: %0d chars, %0d found, %0d failed images",
             n_checked, n_chars, n_found, n_fail);
    if (errors == 0) begin
      $display("lsb_message_extractor: match");
    end else begin
      $display("lsb_message_extractor: mismatch");
    end
    $finish;
  end

endmodule
